// ===== rtl/core/ecv_pkg.sv =====
// ----------------------------------------------------------------------------
// ecv_pkg
// Widths, status codes and stage records for the elastic collision pipeline.
// ----------------------------------------------------------------------------
package ecv_pkg;

  localparam int D_W    = 33;            // coordinate difference magnitude
  localparam int P_W    = 2 * D_W;       // products and dot product
  localparam int K_W    = D_W + 16;      // |d| * m2
  localparam int KH_W   = 25;            // half of the doubled k term
  localparam int PP_W   = D_W + KH_W;    // partial product width
  localparam int DP_W   = D_W + 17;      // denominator partial width
  localparam int NUM_W  = 116;
  localparam int DEN_W  = 83;
  localparam int Q_W    = 42;
  localparam int REM_W  = DEN_W + Q_W + 1;
  localparam int SUM_W  = Q_W + 2;

  localparam logic [Q_W-1:0] Q_LIMIT = Q_W'(64'd1 << 40);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [D_W-1:0]     adx, ady, awx, awy;
    logic               sdx, sdy, swx, swy;
    logic signed [31:0] v1x, v1y;
    logic [15:0]        m1, m2;
    logic               degen;
  } ecv_s1_t;

  typedef struct packed {
    logic [P_W-1:0]     px, py, sqx, sqy;
    logic [K_W-1:0]     kx, ky;
    logic [16:0]        msum;
    logic               nx, ny, sdx, sdy;
    logic signed [31:0] v1x, v1y;
    logic               degen;
  } ecv_s2_t;

  typedef struct packed {
    logic [P_W-1:0]     dot, sumsq;
    logic [K_W-1:0]     kx, ky;
    logic [16:0]        msum;
    logic               negx, negy;
    logic signed [31:0] v1x, v1y;
    logic               degen;
  } ecv_s3_t;

  typedef struct packed {
    logic [PP_W-1:0]    xa, xb, xc, xd, ya, yb, yc, yd;
    logic [DP_W-1:0]    dl, dh;
    logic               negx, negy;
    logic signed [31:0] v1x, v1y;
    logic               degen;
  } ecv_s4_t;

  typedef struct packed {
    logic [NUM_W-1:0]   numx, numy;
    logic [DEN_W-1:0]   den;
    logic               negx, negy;
    logic signed [31:0] v1x, v1y;
    logic               degen;
  } ecv_s5_t;

  typedef struct packed {
    logic [REM_W-1:0]   remx, remy;
    logic [DEN_W-1:0]   den;
    logic [Q_W-1:0]     qx, qy;
    logic               ovx, ovy;
    logic               negx, negy;
    logic signed [31:0] v1x, v1y;
    logic               degen;
  } ecv_div_t;

endpackage

// ===== rtl/core/elastic_collision_velocity_2d.sv =====
// ----------------------------------------------------------------------------
// elastic_collision_velocity_2d
// First body's velocity after an elastic collision of two round bodies.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per body pair (centres, velocities, masses).
// Output channel m_*: new velocity of the first body in m_tdata, status in
// m_tuser (0 ok, 1 coincident centres or zero total mass, 2 saturated).
// The pipeline has six front stages (differences, products, dot product,
// partial products, sums, overflow check), one stage per quotient bit of the
// 42-bit two-lane divider, and the output register.
// Throughput is one item per cycle unless m_tready stalls; each stage has its
// own valid bit and takes a new item whenever it is empty or its successor
// moves on, so bubbles close up under a stall and s_tready stays high until
// every stage holds an item. A stall at m_tready holds the output item unchanged.
// Synchronous reset clears all valid bits; no items are in flight after it.
// ----------------------------------------------------------------------------
module elastic_collision_velocity_2d import ecv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
  // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_vel_x, new_vel_y
  output logic [63:0]  m_tdata,
  // status
  output logic [1:0]   m_tuser
);

  ecv_s1_t  s1, s1_next;
  ecv_s2_t  s2, s2_next;
  ecv_s3_t  s3, s3_next;
  ecv_s4_t  s4, s4_next;
  ecv_s5_t  s5, s5_next;
  ecv_div_t s6, s6_next, dq;
  logic     v1, v2, v3, v4, v5, v6, v7;
  logic     r1, r2, r3, r4, r5, r6, r7;
  logic     div_ready, dq_valid;

  assign r7 = !v7 || m_tready;
  assign r6 = !v6 || div_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  function automatic logic [D_W-1:0] mag(input logic [D_W-1:0] x);
    return x[D_W-1] ? D_W'(-x) : x;
  endfunction

  // returns {saturated, value}
  function automatic logic [32:0] apply_lane(input logic signed [31:0] v,
                                             input logic neg,
                                             input logic [Q_W-1:0] q,
                                             input logic ov);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] qs;
    qs  = $signed({2'b00, q});
    sum = neg ? (SUM_W'(v) - qs) : (SUM_W'(v) + qs);
    if (ov || q > Q_LIMIT) begin
      return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
    end else if (!sum[SUM_W-1] && (sum[SUM_W-2:31] != '0)) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:31])) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, sum[31:0]};
  endfunction

  // stage 1: differences and magnitudes
  always_comb begin
    logic [D_W-1:0] dx, dy, wx, wy;
    dx = D_W'($signed(s_tdata[175:144])) - D_W'($signed(s_tdata[31:0]));
    dy = D_W'($signed(s_tdata[207:176])) - D_W'($signed(s_tdata[63:32]));
    wx = D_W'($signed(s_tdata[239:208])) - D_W'($signed(s_tdata[95:64]));
    wy = D_W'($signed(s_tdata[271:240])) - D_W'($signed(s_tdata[127:96]));
    s1_next.adx   = mag(dx);
    s1_next.ady   = mag(dy);
    s1_next.awx   = mag(wx);
    s1_next.awy   = mag(wy);
    s1_next.sdx   = dx[D_W-1];
    s1_next.sdy   = dy[D_W-1];
    s1_next.swx   = wx[D_W-1];
    s1_next.swy   = wy[D_W-1];
    s1_next.v1x   = $signed(s_tdata[95:64]);
    s1_next.v1y   = $signed(s_tdata[127:96]);
    s1_next.m1    = s_tdata[143:128];
    s1_next.m2    = s_tdata[287:272];
    s1_next.degen = ((dx == '0) && (dy == '0)) ||
                    ((s_tdata[143:128] == '0) && (s_tdata[287:272] == '0));
  end

  // stage 2: products
  always_comb begin
    s2_next.px    = P_W'(s1.adx) * P_W'(s1.awx);
    s2_next.py    = P_W'(s1.ady) * P_W'(s1.awy);
    s2_next.sqx   = P_W'(s1.adx) * P_W'(s1.adx);
    s2_next.sqy   = P_W'(s1.ady) * P_W'(s1.ady);
    s2_next.kx    = K_W'(s1.adx) * K_W'(s1.m2);
    s2_next.ky    = K_W'(s1.ady) * K_W'(s1.m2);
    s2_next.msum  = 17'(s1.m1) + 17'(s1.m2);
    s2_next.nx    = s1.sdx ^ s1.swx;
    s2_next.ny    = s1.sdy ^ s1.swy;
    s2_next.sdx   = s1.sdx;
    s2_next.sdy   = s1.sdy;
    s2_next.v1x   = s1.v1x;
    s2_next.v1y   = s1.v1y;
    s2_next.degen = s1.degen;
  end

  // stage 3: signed dot product magnitude, |d|^2
  always_comb begin
    logic dneg;
    if (s2.nx == s2.ny) begin
      s3_next.dot = s2.px + s2.py;
      dneg        = s2.nx;
    end else if (s2.px >= s2.py) begin
      s3_next.dot = s2.px - s2.py;
      dneg        = s2.nx;
    end else begin
      s3_next.dot = s2.py - s2.px;
      dneg        = s2.ny;
    end
    s3_next.sumsq = s2.sqx + s2.sqy;
    s3_next.kx    = s2.kx;
    s3_next.ky    = s2.ky;
    s3_next.msum  = s2.msum;
    s3_next.negx  = s2.sdx ^ dneg;
    s3_next.negy  = s2.sdy ^ dneg;
    s3_next.v1x   = s2.v1x;
    s3_next.v1y   = s2.v1y;
    s3_next.degen = s2.degen;
  end

  // stage 4: partial products of numerators and denominator
  always_comb begin
    logic [2*KH_W-1:0] k2x, k2y;
    logic [D_W-1:0]    dlo, dhi;
    k2x = {s3.kx, 1'b0};
    k2y = {s3.ky, 1'b0};
    dlo = s3.dot[D_W-1:0];
    dhi = s3.dot[P_W-1:D_W];
    s4_next.xa    = PP_W'(dlo) * PP_W'(k2x[KH_W-1:0]);
    s4_next.xb    = PP_W'(dlo) * PP_W'(k2x[2*KH_W-1:KH_W]);
    s4_next.xc    = PP_W'(dhi) * PP_W'(k2x[KH_W-1:0]);
    s4_next.xd    = PP_W'(dhi) * PP_W'(k2x[2*KH_W-1:KH_W]);
    s4_next.ya    = PP_W'(dlo) * PP_W'(k2y[KH_W-1:0]);
    s4_next.yb    = PP_W'(dlo) * PP_W'(k2y[2*KH_W-1:KH_W]);
    s4_next.yc    = PP_W'(dhi) * PP_W'(k2y[KH_W-1:0]);
    s4_next.yd    = PP_W'(dhi) * PP_W'(k2y[2*KH_W-1:KH_W]);
    s4_next.dl    = DP_W'(s3.sumsq[D_W-1:0]) * DP_W'(s3.msum);
    s4_next.dh    = DP_W'(s3.sumsq[P_W-1:D_W]) * DP_W'(s3.msum);
    s4_next.negx  = s3.negx;
    s4_next.negy  = s3.negy;
    s4_next.v1x   = s3.v1x;
    s4_next.v1y   = s3.v1y;
    s4_next.degen = s3.degen;
  end

  // stage 5: sum partial products
  always_comb begin
    s5_next.numx  = NUM_W'(s4.xa) + (NUM_W'(s4.xb) << KH_W) +
                    (NUM_W'(s4.xc) << D_W) + (NUM_W'(s4.xd) << (D_W + KH_W));
    s5_next.numy  = NUM_W'(s4.ya) + (NUM_W'(s4.yb) << KH_W) +
                    (NUM_W'(s4.yc) << D_W) + (NUM_W'(s4.yd) << (D_W + KH_W));
    s5_next.den   = DEN_W'(s4.dl) + (DEN_W'(s4.dh) << D_W);
    s5_next.negx  = s4.negx;
    s5_next.negy  = s4.negy;
    s5_next.v1x   = s4.v1x;
    s5_next.v1y   = s4.v1y;
    s5_next.degen = s4.degen;
  end

  // stage 6: quotient range check
  always_comb begin
    s6_next.remx  = REM_W'(s5.numx);
    s6_next.remy  = REM_W'(s5.numy);
    s6_next.den   = s5.den;
    s6_next.qx    = '0;
    s6_next.qy    = '0;
    s6_next.ovx   = REM_W'(s5.numx) >= (REM_W'(s5.den) << Q_W);
    s6_next.ovy   = REM_W'(s5.numy) >= (REM_W'(s5.den) << Q_W);
    s6_next.negx  = s5.negx;
    s6_next.negy  = s5.negy;
    s6_next.v1x   = s5.v1x;
    s6_next.v1y   = s5.v1y;
    s6_next.degen = s5.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) s1 <= s1_next;
    if (r2) s2 <= s2_next;
    if (r3) s3 <= s3_next;
    if (r4) s4 <= s4_next;
    if (r5) s5 <= s5_next;
    if (r6) s6 <= s6_next;
  end

  ecv_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_ready  (div_ready),
    .in_data   (s6),
    .out_valid (dq_valid),
    .out_ready (r7),
    .out_data  (dq)
  );

  // stage 7: apply correction, clamp, output register
  logic [32:0] ax, ay;
  assign ax = apply_lane(dq.v1x, dq.negx, dq.qx, dq.ovx);
  assign ay = apply_lane(dq.v1y, dq.negy, dq.qy, dq.ovy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (r7) begin
      v7 <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      if (dq.degen) begin
        m_tdata <= {dq.v1y, dq.v1x};
        m_tuser <= ST_DEGEN;
      end else begin
        m_tdata <= {ay[31:0], ax[31:0]};
        m_tuser <= (ax[32] || ay[32]) ? ST_SAT : ST_OK;
      end
    end
  end

  assign m_tvalid = v7;

endmodule

// ===== rtl/core/ecv_divider.sv =====
// ----------------------------------------------------------------------------
// ecv_divider
// Restoring divider, one quotient bit per register stage, two lanes.
// ----------------------------------------------------------------------------
module ecv_divider import ecv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ecv_div_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ecv_div_t out_data
);

  ecv_div_t         stg [Q_W];
  ecv_div_t         src [Q_W];
  ecv_div_t         nxt [Q_W];
  logic [Q_W-1:0]   vld;
  logic [Q_W-1:0]   srcv;
  logic [Q_W:0]     rdy;

  assign rdy[Q_W] = out_ready;

  genvar j;
  generate
    for (j = 0; j < Q_W; j++) begin : g_stage
      localparam int I = Q_W - 1 - j;
      logic [REM_W:0] shd, tx, ty;

      if (j == 0) begin : g_first
        assign src[j]  = in_data;
        assign srcv[j] = in_valid;
      end else begin : g_rest
        assign src[j]  = stg[j-1];
        assign srcv[j] = vld[j-1];
      end

      assign rdy[j] = !vld[j] || rdy[j+1];

      always_comb begin
        shd    = (REM_W + 1)'(src[j].den) << I;
        tx     = {1'b0, src[j].remx} - shd;
        ty     = {1'b0, src[j].remy} - shd;
        nxt[j] = src[j];
        if (!tx[REM_W]) begin
          nxt[j].remx  = tx[REM_W-1:0];
          nxt[j].qx[I] = 1'b1;
        end
        if (!ty[REM_W]) begin
          nxt[j].remy  = ty[REM_W-1:0];
          nxt[j].qy[I] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (rdy[j]) begin
          vld[j] <= srcv[j];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          stg[j] <= nxt[j];
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld[Q_W-1];
  assign out_data  = stg[Q_W-1];

endmodule

// ===== rtl/core/ecv_checker.sv =====
// ----------------------------------------------------------------------------
// ecv_checker
// Port-level checks on the collision pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ecv_checker import ecv_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [287:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("item out after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_DEGEN || m_tuser == ST_SAT))
    else $error("bad status");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_SAT) |->
      (m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
       m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000))
    else $error("saturated item without clamped component");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output item changed under stall");

endmodule

bind elastic_collision_velocity_2d ecv_checker u_ecv_checker (.*);
